>>> rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rfc_pkg.sv
package rfc_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CSFAIL   = 3'd1,
    ST_BADFIRST = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_BADSIZE  = 3'd4,
    ST_TIMEOUT  = 3'd5,
    ST_BADSUM   = 3'd6
  } status_t;

  localparam logic [7:0] ACK_CODE        = 8'h06;
  localparam logic [7:0] CSFAIL_CODE     = 8'h51;
  localparam logic [7:0] TIMEOUT_DEFAULT = 8'd20;

  localparam logic REG_IDLE_TIMEOUT = 1'b0;

endpackage

>>> rtl/response_frame_checker.sv
// response_frame_checker: checks a sensor's serial reply frame
// input channel (in_valid / in_stall) carries one beat per start, received
// byte or idle poll tick; kind selects which
// a start opens a frame, bytes are counted and summed, idle ticks end the
// frame on a bare ack, a full frame or a run-down of idle_timeout_ticks
// output channel (out_valid / out_stall) carries one status beat per frame
// the status beat is registered: it loads the output register, or the skid entry while the output is held
// throughput: one input beat per cycle while in_stall is low; all state updates in a single pass
// the output register is backed by one skid entry; in_stall rises only when
// both are full, that is after the receiver stalls with a second result
// pending
// reset clears the frame state, empties both output entries and loads the
// idle timeout register with 20
// the apb port writes and reads idle_timeout_ticks at byte address 0
`include "assert_macros.svh"

module response_frame_checker #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  rx_byte,
  input  logic [4:0]  expected_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  byte_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  logic [7:0]       idle_timeout_ticks;
  logic             active, active_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [7:0]       length_byte, length_byte_next;
  logic [7:0]       byte_sum, byte_sum_next;
  logic [7:0]       last_byte, last_byte_next;
  rfc_pkg::status_t error_code, error_code_next;
  logic [4:0]       want_length, want_length_next;
  logic [7:0]       idle_left, idle_left_next;

  logic             res_valid;
  rfc_pkg::status_t res_status;
  logic             skid_valid;
  logic [2:0]       skid_status;
  logic [5:0]       skid_count;

  logic             in_acc, out_pop;
  logic             bare_ack, full_frame, timed_out;
  logic [7:0]       idle_dec, cnt8;
  rfc_pkg::status_t err_end;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == rfc_pkg::REG_IDLE_TIMEOUT) ? {24'd0, idle_timeout_ticks} : 32'd0;
  assign in_acc  = in_valid && !in_stall;
  assign out_pop = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ticks <= rfc_pkg::TIMEOUT_DEFAULT;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rfc_pkg::REG_IDLE_TIMEOUT) begin
      idle_timeout_ticks <= pwdata[7:0];
    end
  end

  assign cnt8     = 8'(stored_count);
  assign idle_dec = idle_left - 8'd1;

  always_comb begin
    active_next       = active;
    stored_count_next = stored_count;
    length_byte_next  = length_byte;
    byte_sum_next     = byte_sum;
    last_byte_next    = last_byte;
    error_code_next   = error_code;
    want_length_next  = want_length;
    idle_left_next    = idle_left;
    res_valid         = 1'b0;
    res_status        = error_code;
    bare_ack          = (want_length == 5'd0) && (stored_count == CNT_W'(1));
    full_frame        = !bare_ack && (cnt8 >= 8'(want_length) + 8'd2);
    timed_out         = !bare_ack && !full_frame && (idle_dec == 8'd0);
    err_end           = error_code;
    if (error_code == rfc_pkg::ST_OK) begin
      if (full_frame && length_byte != cnt8) begin
        err_end = rfc_pkg::ST_BADSIZE;
      end else if (timed_out) begin
        err_end = rfc_pkg::ST_TIMEOUT;
      end
    end
    if (err_end == rfc_pkg::ST_OK && !timed_out && stored_count > CNT_W'(1) &&
        (byte_sum - last_byte) != last_byte) begin
      err_end = rfc_pkg::ST_BADSUM;
    end
    if (in_acc) begin
      case (rfc_pkg::kind_t'(kind))
        rfc_pkg::KIND_START: begin
          active_next       = 1'b1;
          stored_count_next = '0;
          length_byte_next  = 8'd0;
          byte_sum_next     = 8'd0;
          last_byte_next    = 8'd0;
          error_code_next   = rfc_pkg::ST_OK;
          want_length_next  = expected_length;
          idle_left_next    = idle_timeout_ticks;
        end
        rfc_pkg::KIND_BYTE: begin
          if (active) begin
            idle_left_next = idle_timeout_ticks;
            if (error_code == rfc_pkg::ST_OK) begin
              if (stored_count < CNT_W'(BUFFER_BYTES)) begin
                if (stored_count == '0) begin
                  if (rx_byte == rfc_pkg::CSFAIL_CODE) begin
                    error_code_next = rfc_pkg::ST_CSFAIL;
                  end else if (rx_byte != rfc_pkg::ACK_CODE) begin
                    error_code_next = rfc_pkg::ST_BADFIRST;
                  end
                end else if (stored_count == CNT_W'(1)) begin
                  length_byte_next = rx_byte;
                end
                byte_sum_next     = byte_sum + rx_byte;
                last_byte_next    = rx_byte;
                stored_count_next = stored_count + CNT_W'(1);
              end else begin
                error_code_next = rfc_pkg::ST_OVERFLOW;
              end
            end
          end
        end
        rfc_pkg::KIND_TICK: begin
          if (active) begin
            if (!bare_ack && !full_frame) begin
              idle_left_next = idle_dec;
            end
            if (bare_ack || full_frame || timed_out) begin
              error_code_next = err_end;
              res_status      = err_end;
              res_valid       = 1'b1;
              active_next     = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      stored_count <= '0;
      length_byte  <= 8'd0;
      byte_sum     <= 8'd0;
      last_byte    <= 8'd0;
      error_code   <= rfc_pkg::ST_OK;
      want_length  <= 5'd0;
      idle_left    <= rfc_pkg::TIMEOUT_DEFAULT;
    end else begin
      active       <= active_next;
      stored_count <= stored_count_next;
      length_byte  <= length_byte_next;
      byte_sum     <= byte_sum_next;
      last_byte    <= last_byte_next;
      error_code   <= error_code_next;
      want_length  <= want_length_next;
      idle_left    <= idle_left_next;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        status     <= skid_status;
        byte_count <= skid_count;
      end
    end else if (res_valid) begin
      if (!out_valid || out_pop) begin
        status     <= res_status;
        byte_count <= 6'(stored_count);
      end else begin
        skid_status <= res_status;
        skid_count  <= 6'(stored_count);
      end
    end
  end

  `CHK_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full with output empty")
  `CHK_NEXT(a_close_on_result, clk, rst, res_valid, !active && out_valid,
            "frame still open after status beat")
  `CHK_NEXT(a_error_latched, clk, rst,
            active && error_code != rfc_pkg::ST_OK &&
            !(in_acc && kind == rfc_pkg::KIND_START),
            error_code == $past(error_code), "latched error changed")
  `CHK_SAME(a_count_bound, clk, rst, 1'b1, stored_count <= CNT_W'(BUFFER_BYTES),
            "byte count beyond buffer")

endmodule

>>> verif/response_frame_checker_test.sv
`timescale 1ns / 100ps

module response_frame_checker_test;
  import rfc_pkg::*;

  localparam int FRAME_BUFFER = 32;
  localparam logic [2:0] TIMEOUT_ADDR = 3'(4 * REG_IDLE_TIMEOUT);
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic [4:0] len;
  } rx_beat_t;

  typedef struct {
    status_t    code;
    logic [5:0] count;
  } frame_result_t;

  typedef enum {
    FLAW_NONE, FLAW_BADSUM, FLAW_CSFAIL, FLAW_BADFIRST, FLAW_OVERFLOW, FLAW_BADSIZE,
    FLAW_EXTRA, FLAW_TIMEOUT, FLAW_BARE, FLAW_ABANDON, FLAW_NOISE
  } frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_NONE;
  logic [7:0]  rx_byte = 8'd0;
  logic [4:0]  expected_length = 5'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  byte_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  rx_beat_t      pending_beats[$];
  frame_result_t expected_status[$];

  int cycle_no = 0;
  int beats_queued = 0;
  int beats_taken = 0;
  int results_checked = 0;
  int mismatches = 0;
  int hold_epoch = 0;
  int status_seen[7];

  // frame tracking state
  logic       frame_open;
  logic [5:0] frame_bytes;
  logic [7:0] len_field;
  logic [7:0] run_sum;
  logic [7:0] tail_byte;
  logic [7:0] idle_left;
  logic [4:0] want_len;
  status_t    frame_status;
  logic [7:0] timeout_ticks = TIMEOUT_DEFAULT;

  response_frame_checker #(.BUFFER_BYTES(FRAME_BUFFER)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .rx_byte(rx_byte), .expected_length(expected_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .byte_count(byte_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_no <= cycle_no + 1;

  function automatic bit take_break();
    return (cycle_no < 800 || cycle_no >= 2000) && $urandom_range(99) < 23;
  endfunction

  task automatic track_frame(kind_t k, logic [7:0] b, logic [4:0] len);
    logic finished;
    logic expired;
    finished = 1'b0;
    expired = 1'b0;
    case (k)
      KIND_START: begin
        frame_open = 1'b1;
        frame_bytes = 6'd0;
        len_field = 8'd0;
        run_sum = 8'd0;
        tail_byte = 8'd0;
        frame_status = ST_OK;
        want_len = len;
        idle_left = timeout_ticks;
      end
      KIND_BYTE: if (frame_open) begin
        idle_left = timeout_ticks;
        if (frame_status == ST_OK) begin
          if (frame_bytes < FRAME_BUFFER) begin
            if (frame_bytes == 0) begin
              if (b == CSFAIL_CODE) frame_status = ST_CSFAIL;
              else if (b != ACK_CODE) frame_status = ST_BADFIRST;
            end else if (frame_bytes == 1) begin
              len_field = b;
            end
            run_sum = run_sum + b;
            tail_byte = b;
            frame_bytes = frame_bytes + 1;
          end else begin
            frame_status = ST_OVERFLOW;
          end
        end
      end
      KIND_TICK: if (frame_open) begin
        if (want_len == 0 && frame_bytes == 1) begin
          finished = 1'b1;
        end else if (int'(frame_bytes) >= int'(want_len) + 2) begin
          if (frame_status == ST_OK && len_field != {2'b00, frame_bytes})
            frame_status = ST_BADSIZE;
          finished = 1'b1;
        end else begin
          idle_left = idle_left - 1;
          if (idle_left == 0) begin
            finished = 1'b1;
            expired = 1'b1;
            if (frame_status == ST_OK) frame_status = ST_TIMEOUT;
          end
        end
        if (finished) begin
          if (frame_status == ST_OK && !expired && frame_bytes > 1 &&
              8'(run_sum - tail_byte) != tail_byte)
            frame_status = ST_BADSUM;
          expected_status.push_back('{frame_status, frame_bytes});
          frame_open = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : feed
    rx_beat_t beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_beats.size() != 0 && !take_break()) begin
        beat = pending_beats.pop_front();
        in_valid <= 1'b1;
        kind <= beat.kind;
        rx_byte <= beat.data;
        expected_length <= beat.len;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      frame_open = 1'b0;
      frame_bytes = 6'd0;
      len_field = 8'd0;
      run_sum = 8'd0;
      tail_byte = 8'd0;
      frame_status = ST_OK;
      want_len = 5'd0;
      idle_left = timeout_ticks;
    end else if (in_valid && !in_stall) begin
      beats_taken++;
      track_frame(kind_t'(kind), rx_byte, expected_length);
    end
  end

  always @(posedge clk) begin : drain_side
    int seen_epoch;
    int hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      seen_epoch = 0;
      hold_left = 0;
    end else if (hold_epoch != seen_epoch) begin
      seen_epoch = hold_epoch;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= take_break();
    end
  end

  always @(posedge clk) begin : check
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $error("status beat %0d/%0d with nothing expected", status, byte_count);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        results_checked++;
        if (int'(want.code) < 7) status_seen[want.code]++;
        if (status !== want.code) begin
          $error("status: expected %0d, actual %0d", want.code, status);
          mismatches++;
        end
        if (byte_count !== want.count) begin
          $error("byte_count: expected %0d, actual %0d", want.count, byte_count);
          mismatches++;
        end
      end
    end
  end

  task automatic push_beat(kind_t k, logic [7:0] b, logic [4:0] len);
    pending_beats.push_back('{k, b, len});
    beats_queued++;
  endtask

  task automatic push_tick();
    push_beat(KIND_TICK, 8'($urandom), 5'($urandom));
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_timeout(logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    timeout_ticks = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata[7:0] !== value) begin
      $error("idle_timeout_ticks: expected %0d, actual %0d", value, prdata[7:0]);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic frame_flaw_t pick_flaw();
    int r;
    r = $urandom_range(99);
    if (r < 40) return FLAW_NONE;
    if (r < 48) return FLAW_BADSUM;
    if (r < 53) return FLAW_CSFAIL;
    if (r < 58) return FLAW_BADFIRST;
    if (r < 63) return FLAW_OVERFLOW;
    if (r < 69) return FLAW_BADSIZE;
    if (r < 75) return FLAW_EXTRA;
    if (r < 81) return FLAW_TIMEOUT;
    if (r < 87) return FLAW_BARE;
    if (r < 92) return FLAW_ABANDON;
    return FLAW_NOISE;
  endfunction

  task automatic queue_frame(frame_flaw_t flaw);
    int want;
    int total;
    int sent;
    int idx;
    int ticks;
    logic [7:0] sum;
    logic [7:0] b;
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(4, 1))
        push_beat(kind_t'($urandom_range(3)), 8'($urandom), 5'($urandom));
      return;
    end
    want = ($urandom_range(3) == 0) ? $urandom_range(30, 1) : $urandom_range(6, 1);
    if (flaw == FLAW_BARE) want = 0;
    total = want + 2;
    case (flaw)
      FLAW_OVERFLOW: sent = FRAME_BUFFER + $urandom_range(4, 1);
      FLAW_EXTRA: sent = total + $urandom_range(3, 1);
      FLAW_TIMEOUT, FLAW_ABANDON: sent = $urandom_range(total - 1, 0);
      FLAW_BARE: sent = 1;
      default: sent = total;
    endcase
    push_beat(KIND_START, 8'($urandom), 5'(want));
    sum = 8'd0;
    for (idx = 0; idx < sent; idx++) begin
      if (idx == 0) begin
        if (flaw == FLAW_CSFAIL) begin
          b = CSFAIL_CODE;
        end else if (flaw == FLAW_BADFIRST) begin
          do b = 8'($urandom);
          while (b == ACK_CODE || b == CSFAIL_CODE);
        end else begin
          b = ACK_CODE;
        end
      end else if (idx == 1) begin
        b = (flaw == FLAW_BADSIZE) ? 8'(total + $urandom_range(200, 1)) : 8'(total);
      end else if (idx == total - 1) begin
        b = (flaw == FLAW_BADSUM) ? sum ^ 8'($urandom_range(255, 1)) : sum;
      end else begin
        b = 8'($urandom);
      end
      push_beat(KIND_BYTE, b, 5'($urandom));
      sum = sum + b;
      // a stray tick inside the frame
      if (flaw != FLAW_TIMEOUT && idx + 1 < sent && $urandom_range(24) == 0) push_tick();
    end
    if (flaw == FLAW_ABANDON) return;
    ticks = 1;
    if (flaw == FLAW_TIMEOUT) ticks = (timeout_ticks == 0) ? 256 : int'(timeout_ticks);
    repeat (ticks + $urandom_range(1)) push_tick();
  endtask

  task automatic fill_phase(int budget);
    int first;
    bit slow_timeout_done;
    frame_flaw_t flaw;
    first = beats_queued;
    slow_timeout_done = 1'b0;
    while (beats_queued - first < budget) begin
      flaw = pick_flaw();
      // long timeouts are costly, keep one per phase
      if (flaw == FLAW_TIMEOUT && (timeout_ticks == 0 || timeout_ticks > 40)) begin
        if (slow_timeout_done) flaw = FLAW_NONE;
        slow_timeout_done = 1'b1;
      end
      queue_frame(flaw);
    end
    // close any open frame with a bare ack
    push_beat(KIND_START, 8'($urandom), 5'd0);
    push_beat(KIND_BYTE, ACK_CODE, 5'($urandom));
    push_tick();
  endtask

  initial begin : stimulus
    logic [7:0] settings[5];
    int idx;
    settings = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd5};
    settings[3] = 8'($urandom_range(60, 2));
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // beats with no frame open, and the unused kind
    push_beat(KIND_TICK, 8'hFF, 5'd31);
    push_beat(KIND_BYTE, 8'hFF, 5'd31);
    push_beat(KIND_NONE, 8'h00, 5'd0);
    // bare ack
    push_beat(KIND_START, 8'h00, 5'd0);
    push_beat(KIND_BYTE, ACK_CODE, 5'd0);
    push_beat(KIND_TICK, 8'h00, 5'd0);
    // shortest full frame
    push_beat(KIND_START, 8'h00, 5'd1);
    push_beat(KIND_BYTE, ACK_CODE, 5'd0);
    push_beat(KIND_BYTE, 8'd3, 5'd0);
    push_beat(KIND_BYTE, 8'd9, 5'd0);
    push_beat(KIND_TICK, 8'h00, 5'd0);
    // device checksum fail as a one-byte reply
    push_beat(KIND_START, 8'hFF, 5'd0);
    push_beat(KIND_BYTE, CSFAIL_CODE, 5'd0);
    push_beat(KIND_TICK, 8'hFF, 5'd31);
    // bad first byte, then abandoned by a new start
    push_beat(KIND_START, 8'hFF, 5'd31);
    push_beat(KIND_BYTE, 8'h00, 5'd0);
    push_beat(KIND_START, 8'h00, 5'd2);
    push_beat(KIND_BYTE, ACK_CODE, 5'd0);
    push_beat(KIND_BYTE, 8'd4, 5'd0);
    push_beat(KIND_BYTE, 8'h55, 5'd0);
    push_beat(KIND_BYTE, 8'h5F, 5'd0);
    push_beat(KIND_TICK, 8'h00, 5'd0);
    fill_phase(130);
    drain();

    for (idx = 0; idx < 5; idx++) begin
      write_timeout(settings[idx]);
      @(negedge clk);
      fill_phase(130);
      drain();
    end

    // receiver holds off while short frames keep coming
    hold_epoch++;
    repeat (40) queue_frame(FLAW_BARE);
    drain();
    repeat (10) @(negedge clk);

    if (expected_status.size() != 0) begin
      $error("%0d status beats never arrived", expected_status.size());
      mismatches++;
    end
    $display("covered %0d input beats and %0d status beats over six idle timeout settings",
             beats_taken, results_checked);
    $display("status mix: ok %0d, dev fail %0d, bad first %0d, overflow %0d, size %0d, %s",
             status_seen[ST_OK], status_seen[ST_CSFAIL], status_seen[ST_BADFIRST],
             status_seen[ST_OVERFLOW], status_seen[ST_BADSIZE],
             $sformatf("timeout %0d, bad sum %0d", status_seen[ST_TIMEOUT],
                       status_seen[ST_BADSUM]));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
